>>> rtl/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared constants, register codes and the quarter-wave sine evaluator used
// to build the sine ROM of the tone generator at elaboration.
// ----------------------------------------------------------------------------
package stg_pkg;

   // configuration register widths
   localparam int STEP_BITS = 32;
   localparam int AMP_BITS  = 16;

   // register index codes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_PHASE_STEP = 1'b0;
   localparam csr_index_type CSR_AMPLITUDE  = 1'b1;

   // register reset values
   localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 32'd89478485;
   localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET  = 16'd3277;

   // sine magnitude in Q30, stored in 31 bits
   localparam int S_BITS = 31;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // Horner form of the Taylor series up to x^11, floor at every step.
   // k is a quarter-wave position out of 2^qb.
   function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int qb);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] term;
      x    = ((k << (30 - qb)) * PI_HALF_Q30) >> 30;
      x2   = (x * x) >> 30;
      t    = Q30_ONE;
      term = ((x2 * t) >> 30) / 64'd110;
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd72;
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd42;
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd20;
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      term = ((x2 * t) >> 30) / 64'd6;
      t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
      return (x * t) >> 30;
   endfunction

endpackage

>>> rtl/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator
// Direct digital synthesis sine oscillator: one scaled sine sample per tick.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes the sine ROM read register, then the
// gain multiply, rounding and saturation into the output register that drives
// rsp_tvalid.
// Throughput: one request per cycle unless the output stalls; the phase add and
// ROM address are done in the accept cycle, so back-to-back ticks need no gap.
// Reset (synchronous, active high): phase cleared to zero, phase_step and
// amplitude back to their defaults, pipeline emptied. No clearing pass.
// ----------------------------------------------------------------------------
module sine_tone_generator
   import stg_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] restart, zero padded
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [((SAMPLE_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
                                             // [SAMPLE_BITS-1:0] sample,
                                             // [SAMPLE_BITS] cycle_wrapped, zero padded
   // configuration write port
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [STEP_BITS-1:0] csr_wdata
);

   localparam int RSP_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8;

   // quarter wave: Q address bits, QLEN+1 ROM entries (both ends included)
   localparam int Q      = TABLE_ADDR_BITS - 2;
   localparam int QLEN   = 1 << Q;
   localparam int ROM_AW = Q + 1;

   // step may be narrower or wider than the phase accumulator
   localparam int STEP_W = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

   // gain product and rounding
   localparam int PROD_W = S_BITS + AMP_BITS;
   localparam int RND_W  = PROD_W + 1;
   localparam int SH     = 46 - SAMPLE_BITS;
   localparam int MAG_W  = RND_W - SH;
   localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (SH - 1);
   localparam logic [MAG_W-1:0] MAG_MAX    = MAG_W'((2 ** (SAMPLE_BITS - 1)) - 1);

   typedef logic [S_BITS-1:0] rom_type [QLEN+1];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i <= QLEN; i++) begin
         r[i] = S_BITS'(quarter_sine(64'(i), Q));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration registers
   logic [STEP_BITS-1:0] phase_step_ff;
   logic [AMP_BITS-1:0]  amplitude_ff;

   // phase state
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;

   // stage 1: ROM output register
   logic                 s1_valid_ff;
   logic [S_BITS-1:0]    s1_sine_ff;
   logic                 s1_neg_ff;
   logic                 s1_wrap_ff;

   // stage 2: output register
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_wrap_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_in;

   logic                       req_accept;
   logic                       s1_load;
   logic                       s2_load;
   logic [PHASE_BITS-1:0]      phase_cur;
   logic [STEP_W-1:0]          step_wide;
   logic [PHASE_BITS-1:0]      step_cut;
   logic [PHASE_BITS:0]        phase_sum;
   logic [TABLE_ADDR_BITS-1:0] addr;
   logic [1:0]                 quad;
   logic [Q-1:0]               k_raw;
   logic [ROM_AW-1:0]          rom_addr;
   logic [PROD_W-1:0]          prod;
   logic [RND_W-1:0]           rounded;
   logic [MAG_W-1:0]           mag_full;
   logic [SAMPLE_BITS-1:0]     mag_sat;

   // handshakes: stage 2 drains when the output is free or being taken,
   // stage 1 takes a request when empty or moving on
   assign s2_load    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_accept = req_tvalid && req_tready;
   assign s1_load    = req_accept;

   // phase path, all in the accept cycle
   assign phase_cur = req_tdata[0] ? '0 : phase_ff;
   assign step_wide = STEP_W'(phase_step_ff);
   assign step_cut  = step_wide[PHASE_BITS-1:0];
   assign phase_sum = {1'b0, phase_cur} + {1'b0, step_cut};
   assign phase_in  = phase_sum[PHASE_BITS-1:0];

   // quadrant fold: odd quadrants run the quarter wave backwards
   assign addr     = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];
   assign quad     = addr[TABLE_ADDR_BITS-1 -: 2];
   assign k_raw    = addr[Q-1:0];
   assign rom_addr = quad[0] ? (ROM_AW'(QLEN) - {1'b0, k_raw}) : {1'b0, k_raw};

   // gain, round half up, saturate, then apply the sign
   always_comb begin
      prod     = PROD_W'(s1_sine_ff) * PROD_W'(amplitude_ff);
      rounded  = RND_W'(prod) + ROUND_HALF;
      mag_full = rounded[RND_W-1:SH];
      mag_sat  = (mag_full > MAG_MAX) ? SAMPLE_BITS'(MAG_MAX) : mag_full[SAMPLE_BITS-1:0];
      rsp_sample_in = s1_neg_ff ? (SAMPLE_BITS'(0) - mag_sat) : mag_sat;
   end

   // configuration writes; an index with no register is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         amplitude_ff  <= AMPLITUDE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // phase accumulator and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
         end
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // sine ROM read, registered with the rest of stage 1
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sine_ff <= SINE_ROM[rom_addr];
         s1_neg_ff  <= quad[1];
         s1_wrap_ff <= phase_sum[PHASE_BITS];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_wrap_ff   <= s1_wrap_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_wrap_ff, rsp_sample_ff});

`ifndef SYNTH
   // a restart tick leaves exactly one step in the accumulator
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tdata[0] |=> phase_ff == $past(step_cut))
      else $error("phase after restart is not one step");

   // saturation keeps the output symmetric
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
      else $error("sample reached the most negative code");

   // a stage-1 item blocked by the output stays put
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff)
      else $error("stage 1 item lost under stall");

   // a stage-1 item that moves on shows up at the output
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_load |=> rsp_valid_ff)
      else $error("stage 1 item did not reach the output");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sine tone generator. A scoreboard object keeps
// its own phase accumulator and register copies, evaluates the quarter-wave
// sine series in integer math for every accepted request and compares each
// response field by field in order. Both stream sides idle at random; the
// registers are rewritten between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top
   import stg_pkg::*;
();

   localparam int          WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam logic [63:0] Q30            = 64'd1 << 30;
   localparam logic [63:0] PI_HALF        = 64'd1686629713;   // pi/2 in Q30
   localparam logic [63:0] MAG_LIMIT      = 64'd32767;

   // one expected response
   typedef struct packed {
      logic [15:0] sample;
      logic        wrapped;
   } tone_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: integer model of the oscillator plus the queue of pending
   // responses.
   // -------------------------------------------------------------------------
   class tone_scoreboard;
      logic [31:0]     phase;
      logic [31:0]     step;
      logic [15:0]     gain;
      tone_result_type expected_q[$];
      int unsigned     mismatches;

      function new();
         phase      = '0;
         step       = PHASE_STEP_RESET;
         gain       = AMPLITUDE_RESET;
         mismatches = 0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // Q30 sine of quarter-wave position k out of 256, Horner form to x^11
      function logic [63:0] sine_q30(input logic [63:0] k);
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] t;
         logic [63:0] term;
         logic [63:0] divs [0:4];
         divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
         x  = ((k << 22) * PI_HALF) >> 30;
         x2 = (x * x) >> 30;
         t  = Q30;
         foreach (divs[i]) begin
            term = ((x2 * t) >> 30) / divs[i];
            t    = (term >= Q30) ? 64'd0 : Q30 - term;
         end
         return (x * t) >> 30;
      endfunction

      // scaled, rounded, saturated sample for one phase value
      function logic [15:0] tone_value(input logic [31:0] ph);
         logic [1:0]  quad;
         logic [63:0] k;
         logic [63:0] mag;
         logic [15:0] m16;
         quad = ph[31:30];
         k    = {56'd0, ph[29:22]};
         if (quad[0]) begin
            k = 64'd256 - k;   // mirrored quarters, k = 0 maps to the peak
         end
         mag = (sine_q30(k) * {48'd0, gain} + (64'd1 << 29)) >> 30;
         if (mag > MAG_LIMIT) begin
            mag = MAG_LIMIT;
         end
         m16 = mag[15:0];
         return quad[1] ? -m16 : m16;
      endfunction

      // accepted request: restart, sample, then phase advance
      function void note_tick(input logic restart);
         logic [32:0]     sum;
         tone_result_type want;
         if (restart) begin
            phase = '0;
         end
         want.sample  = tone_value(phase);
         sum          = {1'b0, phase} + {1'b0, step};
         want.wrapped = sum[32];
         phase        = sum[31:0];
         expected_q.push_back(want);
      endfunction

      // accepted response: compare with the oldest expectation
      function void check_sample(input logic [23:0] data);
         tone_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request outstanding, data %h", $time, data);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (data[15:0] !== want.sample) begin
            $display("%0t: sample mismatch, expected %0d actual %0d", $time,
                     $signed(want.sample), $signed(data[15:0]));
            mismatches++;
         end
         if (data[16] !== want.wrapped) begin
            $display("%0t: cycle_wrapped mismatch, expected %0b actual %0b", $time,
                     want.wrapped, data[16]);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;    // [0] restart, rest zero
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [23:0]   rsp_tdata;    // [15:0] sample, [16] cycle_wrapped, rest zero
   logic          csr_we;
   csr_index_type csr_index;
   logic [31:0]   csr_wdata;

   sine_tone_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tone_scoreboard board;
   bit             tx_free;      // sender never idles in this phase
   bit             rx_free;      // receiver never stalls in this phase
   int             rx_hold;
   int             idle_cycles;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 19) < 16) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: random back-pressure on the response side
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold    <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rx_free || $urandom_range(0, 9) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rx_hold    <= pick_gap() - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_sample(rsp_tdata);
      end
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   // One request. Valid is only dropped when a gap is taken, so back-to-back
   // requests keep it high without a low/high pair in one time step.
   task automatic send_tick(input logic restart);
      int gap;
      gap = (tx_free || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      board.note_tick(restart);
   endtask

   // hold off until every expected response is in, then a few spare cycles
   task automatic wait_drained();
      while (board.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // both registers, written back to back while the block is idle
   task automatic configure(input logic [31:0] step, input logic [15:0] gain);
      csr_we    <= 1'b1;
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_index <= CSR_AMPLITUDE;
      csr_wdata <= {16'd0, gain};
      @(posedge clock);
      csr_we <= 1'b0;
      board.step = step;
      board.gain = gain;
   endtask

   // One setting: configure, stream requests, drain. Directed phases restart
   // on the first request; random ones restart now and then. hold_midway
   // makes the sender wait for the pipeline to empty halfway through.
   task automatic play_phase(input logic [31:0] step, input logic [15:0] gain,
                             input int n_items, input bit directed, input bit hold_midway);
      configure(step, gain);
      for (int i = 0; i < n_items; i++) begin
         if (hold_midway && i == n_items / 2) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         send_tick(directed ? (i == 0) : ($urandom_range(0, 31) == 0));
      end
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] step;
      logic [15:0] gain;
      board       = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_PHASE_STEP;
      csr_wdata   = '0;
      tx_free     = 1'b0;
      rx_free     = 1'b0;
      rx_hold     = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, restart in the middle of a run
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      req_tvalid <= 1'b0;
      wait_drained();

      // quarter-cycle step at full scale: every quadrant corner, wrap on the fourth tick
      play_phase(32'h4000_0000, 16'd32768, 5, 1'b1, 1'b0);
      // gain above full scale: magnitude saturates on both signs
      play_phase(32'hA000_0000, 16'hFFFF, 4, 1'b1, 1'b0);
      // largest step with zero gain: wraps on every tick after the first
      play_phase(32'hFFFF_FFFF, 16'd0, 4, 1'b1, 1'b0);
      // half-cycle step, gain just under full scale
      play_phase(32'h8000_0000, 16'd32767, 4, 1'b1, 1'b0);
      // frozen phase, smallest nonzero gain
      play_phase(32'd0, 16'd1, 2, 1'b1, 1'b0);

      // random settings, extremes weighted in
      for (int p = 0; p < 12; p++) begin
         tx_free = ($urandom_range(0, 3) == 0);
         rx_free = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       step = 32'd0;
            1:       step = 32'h8000_0000;
            2:       step = 32'hFFFF_FFFF;
            3:       step = $urandom_range(1, 32'h0100_0000);
            default: step = $urandom;
         endcase
         case ($urandom_range(0, 5))
            0:       gain = 16'd0;
            1:       gain = 16'd32768;
            2:       gain = 16'hFFFF;
            default: gain = 16'($urandom_range(0, 65535));
         endcase
         play_phase(step, gain, 160, 1'b0, p == 5);
      end

      // anything arriving late shows up in the monitor
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
